>>> rtl/pcsm_pkg.sv
// ----------------------------------------------------------------------------
// pcsm_pkg
// Types and codes used by the p-code stack machine.
// ----------------------------------------------------------------------------
package pcsm_pkg;

  localparam logic [2:0] OP_LIT = 3'd0;
  localparam logic [2:0] OP_OPR = 3'd1;
  localparam logic [2:0] OP_LOD = 3'd2;
  localparam logic [2:0] OP_STO = 3'd3;
  localparam logic [2:0] OP_CAL = 3'd4;
  localparam logic [2:0] OP_INT = 3'd5;
  localparam logic [2:0] OP_JMP = 3'd6;
  localparam logic [2:0] OP_JPC = 3'd7;

  localparam logic [15:0] OPR_RET = 16'd0;
  localparam logic [15:0] OPR_NEG = 16'd1;
  localparam logic [15:0] OPR_ADD = 16'd2;
  localparam logic [15:0] OPR_SUB = 16'd3;
  localparam logic [15:0] OPR_MUL = 16'd4;
  localparam logic [15:0] OPR_DIV = 16'd5;
  localparam logic [15:0] OPR_ODD = 16'd6;
  localparam logic [15:0] OPR_EQ  = 16'd8;
  localparam logic [15:0] OPR_NE  = 16'd9;
  localparam logic [15:0] OPR_LT  = 16'd10;
  localparam logic [15:0] OPR_GE  = 16'd11;
  localparam logic [15:0] OPR_GT  = 16'd12;
  localparam logic [15:0] OPR_LE  = 16'd13;

  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_DIV0  = 2'd1;
  localparam logic [1:0] ERR_STACK = 2'd2;

  typedef enum logic [4:0] {
    S_CLEAR,
    S_IDLE,
    S_DECODE,
    S_WALK_RD,
    S_WALK,
    S_LOD_WR,
    S_STO_WR,
    S_CAL2,
    S_CAL3,
    S_OPR_RD1,
    S_OPR_RD2,
    S_DIV,
    S_RET_RD1,
    S_RET_RD2,
    S_JPC,
    S_TOP_RD,
    S_TOP
  } state_e;

endpackage

>>> rtl/pcsm_div.sv
// ----------------------------------------------------------------------------
// pcsm_div
// Signed restoring divider, one quotient bit per cycle, truncating to zero.
// ----------------------------------------------------------------------------
module pcsm_div #(
  parameter int WORD_BITS = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  logic [WORD_BITS-1:0] dividend_i,
  input  logic [WORD_BITS-1:0] divisor_i,
  output logic                 done_o,
  output logic [WORD_BITS-1:0] quotient_o
);
  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(W + 1);

  logic          busy_q, done_q, neg_q;
  logic [CW-1:0] cnt_q;
  logic [W-1:0]  quo_q, dsr_q;
  logic [W:0]    rem_q, rem_sh;
  logic [W+1:0]  diff;
  logic          ge;

  assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dsr_q};
  assign ge     = ~diff[W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[W-1] ^ divisor_i[W-1];
      quo_q <= dividend_i[W-1] ? -dividend_i : dividend_i;
      dsr_q <= divisor_i[W-1] ? -divisor_i : divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= ge ? diff[W:0] : rem_sh;
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -quo_q : quo_q;

endmodule

>>> rtl/pcode_stack_machine.sv
// ----------------------------------------------------------------------------
// pcode_stack_machine
// Executes one PL/0 p-code instruction per item against an internal stack.
//
//   channel | signals                                   | direction
//   in      | in_valid_i in_ready_o opcode_i            | host to block
//           | level_diff_i operand_i                    |
//   out     | out_valid_o out_ready_i next_pc_o         | block to host
//           | halted_o error_code_o top_value_o         |
//
// An item steps through more states for each static link followed and for a
// divide; the stack memory gives one read and one write port per step.
// After reset a clearing pass zeroes every stack word before the first item
// is taken. A stalled result holds the block in its last step.
// ----------------------------------------------------------------------------
module pcode_stack_machine #(
  parameter int STACK_DEPTH = 1024,
  parameter int CODE_DEPTH  = 512,
  parameter int WORD_BITS   = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  opcode_i,
  input  logic [2:0]  level_diff_i,
  input  logic [15:0] operand_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [8:0]  next_pc_o,
  output logic        halted_o,
  output logic [1:0]  error_code_o,
  output logic signed [31:0] top_value_o
);
  import pcsm_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int AW = $clog2(STACK_DEPTH);
  localparam int PW = $clog2(CODE_DEPTH);
  localparam int EW = ((AW > 16) ? AW : 16) + 1;

  state_e        state_q, state_d;
  logic [AW-1:0] top_q, top_d, base_q, base_d, chain_q, chain_d, clr_q, clr_d;
  logic [PW-1:0] pc_q, pc_d;
  logic          stop_q, stop_d;
  logic [1:0]    err_q, err_d;
  logic [2:0]    op_q, lev_q, lev_d;
  logic [15:0]   arg_q;
  logic [W-1:0]  b_q, b_d;

  logic [W-1:0]  mem [STACK_DEPTH];
  logic [W-1:0]  rd_q;
  logic [AW-1:0] ra, wa;
  logic [W-1:0]  wd;
  logic          we;

  logic          div_start, div_done;
  logic [W-1:0]  div_quo;

  logic          out_valid_q;
  logic [8:0]    out_pc_q;
  logic          out_halt_q;
  logic [1:0]    out_err_q;
  logic [31:0]   out_top_q;

  logic          push_full, cal_full, int_full;
  logic [AW-1:0] ret_t, frame_addr;
  logic [W-1:0]  bin_r;
  logic          is_binary;

  assign push_full  = (EW'(top_q) + EW'(1)) >= EW'(STACK_DEPTH);
  assign cal_full   = (EW'(top_q) + EW'(3)) >= EW'(STACK_DEPTH);
  assign int_full   = (EW'(top_q) + EW'(arg_q)) >= EW'(STACK_DEPTH);
  assign ret_t      = base_q - 1'b1;
  assign frame_addr = chain_q + AW'(arg_q);
  assign is_binary  = (arg_q >= OPR_ADD && arg_q <= OPR_DIV) ||
                      (arg_q >= OPR_EQ && arg_q <= OPR_LE);

  pcsm_div #(.WORD_BITS(W)) u_div (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (div_start),
    .dividend_i(rd_q),
    .divisor_i (b_q),
    .done_o    (div_done),
    .quotient_o(div_quo)
  );

  always_comb begin
    priority case (arg_q)
      OPR_ADD: bin_r = rd_q + b_q;
      OPR_SUB: bin_r = rd_q - b_q;
      OPR_MUL: bin_r = W'(rd_q * b_q);
      OPR_EQ:  bin_r = W'(rd_q == b_q);
      OPR_NE:  bin_r = W'(rd_q != b_q);
      OPR_LT:  bin_r = W'($signed(rd_q) < $signed(b_q));
      OPR_GE:  bin_r = W'($signed(rd_q) >= $signed(b_q));
      OPR_GT:  bin_r = W'($signed(rd_q) > $signed(b_q));
      default: bin_r = W'($signed(rd_q) <= $signed(b_q));
    endcase
  end

  always_comb begin
    state_d   = state_q;
    top_d     = top_q;
    base_d    = base_q;
    chain_d   = chain_q;
    clr_d     = clr_q;
    pc_d      = pc_q;
    stop_d    = stop_q;
    err_d     = err_q;
    lev_d     = lev_q;
    b_d       = b_q;
    ra        = top_q;
    wa        = top_q;
    wd        = '0;
    we        = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        we    = 1'b1;
        wa    = clr_q;
        clr_d = clr_q + 1'b1;
        if (clr_q == AW'(STACK_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          err_d   = ERR_NONE;
          lev_d   = level_diff_i;
          chain_d = base_q;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_TOP_RD;
        if (!stop_q) begin
          pc_d = pc_q + 1'b1;
          unique case (op_q)
            OP_LIT: begin
              if (push_full) begin
                err_d = ERR_STACK;
              end else begin
                top_d = top_q + 1'b1;
                we    = 1'b1;
                wa    = top_q + 1'b1;
                wd    = W'(arg_q);
              end
            end
            OP_OPR: begin
              if (arg_q == OPR_RET) begin
                top_d   = ret_t;
                ra      = ret_t + AW'(3);
                state_d = S_RET_RD1;
              end else if (is_binary || arg_q == OPR_NEG || arg_q == OPR_ODD) begin
                state_d = S_OPR_RD1;
              end
            end
            OP_LOD: begin
              if (push_full) begin
                err_d = ERR_STACK;
              end else begin
                state_d = S_WALK_RD;
              end
            end
            OP_STO: state_d = S_WALK_RD;
            OP_CAL: begin
              if (cal_full) begin
                err_d = ERR_STACK;
              end else begin
                state_d = S_WALK_RD;
              end
            end
            OP_INT: begin
              if (int_full) begin
                err_d = ERR_STACK;
              end else begin
                top_d = top_q + AW'(arg_q);
              end
            end
            OP_JMP: pc_d = PW'(arg_q);
            default: state_d = S_JPC;
          endcase
        end
      end
      S_WALK_RD: begin
        ra = chain_q;
        if (lev_q != 3'd0) begin
          state_d = S_WALK;
        end else begin
          unique case (op_q)
            OP_LOD: begin
              ra      = frame_addr;
              state_d = S_LOD_WR;
            end
            OP_STO: begin
              ra      = top_q;
              state_d = S_STO_WR;
            end
            default: begin
              we      = 1'b1;
              wa      = top_q + 1'b1;
              wd      = W'(chain_q);
              state_d = S_CAL2;
            end
          endcase
        end
      end
      S_WALK: begin
        chain_d = AW'(rd_q);
        lev_d   = lev_q - 1'b1;
        state_d = S_WALK_RD;
      end
      S_LOD_WR: begin
        we      = 1'b1;
        wa      = top_q + 1'b1;
        wd      = rd_q;
        top_d   = top_q + 1'b1;
        state_d = S_TOP_RD;
      end
      S_STO_WR: begin
        we      = 1'b1;
        wa      = frame_addr;
        wd      = rd_q;
        top_d   = top_q - 1'b1;
        state_d = S_TOP_RD;
      end
      S_CAL2: begin
        we      = 1'b1;
        wa      = top_q + AW'(2);
        wd      = W'(base_q);
        state_d = S_CAL3;
      end
      S_CAL3: begin
        we      = 1'b1;
        wa      = top_q + AW'(3);
        wd      = W'(pc_q);
        base_d  = top_q + 1'b1;
        pc_d    = PW'(arg_q);
        state_d = S_TOP_RD;
      end
      S_OPR_RD1: begin
        b_d = rd_q;
        if (arg_q == OPR_NEG) begin
          we      = 1'b1;
          wd      = -rd_q;
          state_d = S_TOP_RD;
        end else if (arg_q == OPR_ODD) begin
          we      = 1'b1;
          wd      = W'(rd_q[0]);
          state_d = S_TOP_RD;
        end else begin
          top_d   = top_q - 1'b1;
          ra      = top_q - 1'b1;
          state_d = S_OPR_RD2;
        end
      end
      S_OPR_RD2: begin
        state_d = S_TOP_RD;
        if (arg_q == OPR_DIV) begin
          if (b_q == '0) begin
            err_d = ERR_DIV0;
          end else if (b_q == '1) begin
            we = 1'b1;
            wd = -rd_q;
          end else begin
            div_start = 1'b1;
            state_d   = S_DIV;
          end
        end else begin
          we = 1'b1;
          wd = bin_r;
        end
      end
      S_DIV: begin
        if (div_done) begin
          we      = 1'b1;
          wd      = div_quo;
          state_d = S_TOP_RD;
        end
      end
      S_RET_RD1: begin
        pc_d    = PW'(rd_q);
        ra      = top_q + AW'(2);
        state_d = S_RET_RD2;
      end
      S_RET_RD2: begin
        base_d  = AW'(rd_q);
        state_d = S_TOP_RD;
      end
      S_JPC: begin
        if (rd_q == '0) begin
          pc_d = PW'(arg_q);
        end
        top_d   = top_q - 1'b1;
        state_d = S_TOP_RD;
      end
      S_TOP_RD: begin
        if (err_q != ERR_NONE || pc_q == '0) begin
          stop_d = 1'b1;
        end
        state_d = S_TOP;
      end
      default: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = S_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      top_q       <= '0;
      base_q      <= AW'(1);
      pc_q        <= '0;
      stop_q      <= 1'b0;
      err_q       <= ERR_NONE;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      top_q   <= top_d;
      base_q  <= base_d;
      pc_q    <= pc_d;
      stop_q  <= stop_d;
      err_q   <= err_d;
      clr_q   <= clr_d;
      if (state_q == S_TOP && (!out_valid_q || out_ready_i)) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    chain_q <= chain_d;
    lev_q   <= lev_d;
    b_q     <= b_d;
    if (state_q == S_IDLE && in_valid_i) begin
      op_q  <= opcode_i;
      arg_q <= operand_i;
    end
    if (we) begin
      mem[wa] <= wd;
    end
    rd_q <= mem[ra];
    if (state_q == S_TOP && (!out_valid_q || out_ready_i)) begin
      out_pc_q   <= 9'(pc_q);
      out_halt_q <= stop_q;
      out_err_q  <= err_q;
      out_top_q  <= 32'($signed(rd_q));
    end
  end

  assign in_ready_o   = (state_q == S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign next_pc_o    = out_pc_q;
  assign halted_o     = out_halt_q;
  assign error_code_o = out_err_q;
  assign top_value_o  = out_top_q;

endmodule
